[sv/mjdg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MJD to Gregorian date package
// Field widths, calendar constants, the job record passed from the front end
// to the calendar pipeline, and the decimal scale lookup.
// ----------------------------------------------------------------------------
package mjdg_pkg;

  localparam int MJD_W    = 56;
  localparam int YEAR_W   = 23;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int FRAC_W   = 14;
  localparam int DIGITS_W = 3;
  localparam int JD_W     = 30;
  localparam int WHOLE_W  = 30;

  localparam logic [DIGITS_W-1:0] DIGITS_RESET = 3'd1;

  localparam logic [31:0] LOW_LIMIT_DAYS  = 32'd2395520;
  localparam logic [31:0] HIGH_LIMIT_DAYS = 32'd1000000000;
  localparam logic [31:0] JD_OFFSET       = 32'd2400001;

  localparam logic [31:0] CAL_BIAS        = 32'd17918;
  localparam logic [17:0] CAL_CYCLE       = 18'd146097;
  localparam logic [31:0] CAL_SHIFT       = 32'd37;
  localparam logic [10:0] LEAP_CYCLE      = 11'd1461;
  localparam logic [10:0] MONTH_BIAS      = 11'd237;
  localparam logic [10:0] MONTH_WRAP      = 11'd1224;
  localparam logic [22:0] YEAR_BIAS       = 23'd4712;
  localparam logic [9:0]  MONTH_SPAN      = 10'd306;

  // Reciprocals for constant division, floor(2^s / d), with a single
  // compare-and-subtract correction downstream.
  localparam logic [14:0] RECIP_CYCLE = 15'((64'd1 << 32) / 64'd146097);
  localparam logic [21:0] RECIP_LEAP  = 22'((64'd1 << 32) / 64'd1461);
  localparam logic [7:0]  RECIP_SPAN  = 8'((64'd1 << 16) / 64'd306);
  localparam logic [8:0]  RECIP_TEN   = 9'((64'd1 << 12) / 64'd10);

  typedef struct packed {
    logic [JD_W-1:0]   jd;
    logic [FRAC_W-1:0] frac;
    logic              status;
  } mjdg_job_t;

  // Decimal scale for the configured digit count; counts above four act as four.
  function automatic logic [FRAC_W-1:0] fd_for_digits(input logic [DIGITS_W-1:0] digits);
    logic [FRAC_W-1:0] fd;
    case (digits)
      3'd0:    fd = 14'd1;
      3'd1:    fd = 14'd10;
      3'd2:    fd = 14'd100;
      3'd3:    fd = 14'd1000;
      default: fd = 14'd10000;
    endcase
    return fd;
  endfunction

endpackage

[sv/mjdg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MJD to Gregorian date channels
// Valid/ready channels for the input date and the calendar result.
// ----------------------------------------------------------------------------
interface mjdg_in_if;
  import mjdg_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [MJD_W-1:0] mjd_fixed;

  modport source (output valid, output mjd_fixed, input ready);
  modport sink   (input valid, input mjd_fixed, output ready);
endinterface

interface mjdg_out_if;
  import mjdg_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [YEAR_W-1:0] year;
  logic [MONTH_W-1:0]       month;
  logic [DAY_W-1:0]         day_of_month;
  logic [FRAC_W-1:0]        day_fraction;
  logic                     status;

  modport source (output valid, output year, output month, output day_of_month,
                  output day_fraction, output status, input ready);
  modport sink   (input valid, input year, input month, input day_of_month,
                  input day_fraction, input status, output ready);
endinterface

[sv/mjdg_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MJD to Gregorian date front end
// Range check, decimal rounding and floor split into a chronological Julian
// day number and a fraction count, in two pipeline stages.
// ----------------------------------------------------------------------------
module mjdg_front #(
  parameter int FRAC_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [mjdg_pkg::FRAC_W-1:0]   fd_i,
  mjdg_in_if.sink                       in_i,
  output logic                          job_valid_o,
  output mjdg_pkg::mjdg_job_t           job_o,
  input  logic                          job_ready_i
);
  import mjdg_pkg::*;

  localparam int PROD_W = FRAC_BITS + FRAC_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam logic [63:0] LOW_LIM  = 64'(LOW_LIMIT_DAYS) << FRAC_BITS;
  localparam logic [63:0] HIGH_LIM = 64'(HIGH_LIMIT_DAYS) << FRAC_BITS;
  localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);

  logic adv;

  // Stage A: magnitude, range check, fraction times scale.
  logic [MJD_W-1:0]     raw, mag, whole_full;
  logic [FRAC_BITS-1:0] part;
  logic                 neg, oor;

  logic                 a_valid_q;
  logic                 a_neg_q, a_oor_q;
  logic [WHOLE_W-1:0]   a_whole_q;
  logic [PROD_W-1:0]    a_prod_q;
  logic [FRAC_W-1:0]    a_fd_q;

  assign raw        = $unsigned(in_i.mjd_fixed);
  assign neg        = raw[MJD_W-1];
  assign mag        = neg ? (~raw + MJD_W'(1)) : raw;
  assign oor        = neg ? ({8'b0, mag} >= LOW_LIM) : ({8'b0, mag} >= HIGH_LIM);
  assign whole_full = mag >> FRAC_BITS;
  assign part       = mag[FRAC_BITS-1:0];

  // Stage B: round, carry into the day, floor split for negative dates.
  logic [SUM_W-1:0]   sum;
  logic [FRAC_W-1:0]  c, r_mag;
  logic               carry, rnz;
  logic [WHOLE_W:0]   q_mag;
  logic [31:0]        jd_full;
  mjdg_job_t          b_job_d, b_job_q;
  logic               b_valid_q;

  assign sum   = {1'b0, a_prod_q} + HALF;
  assign c     = sum[FRAC_BITS +: FRAC_W];
  assign carry = (c == a_fd_q);
  assign r_mag = carry ? '0 : c;
  assign rnz   = (r_mag != '0);
  assign q_mag = {1'b0, a_whole_q} + (WHOLE_W + 1)'(carry);

  always_comb begin
    if (a_neg_q) begin
      jd_full = JD_OFFSET - 32'(q_mag) - 32'(rnz);
    end else begin
      jd_full = JD_OFFSET + 32'(q_mag);
    end
    b_job_d.jd     = jd_full[JD_W-1:0];
    b_job_d.frac   = (a_neg_q && rnz) ? (a_fd_q - r_mag) : r_mag;
    b_job_d.status = a_oor_q;
  end

  assign adv         = !b_valid_q || job_ready_i;
  assign in_i.ready  = adv;
  assign job_valid_o = b_valid_q;
  assign job_o       = b_job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= in_i.valid;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_neg_q   <= neg;
      a_oor_q   <= oor;
      a_whole_q <= whole_full[WHOLE_W-1:0];
      a_prod_q  <= PROD_W'(part) * PROD_W'(fd_i);
      a_fd_q    <= fd_i;
      b_job_q   <= b_job_d;
    end
  end

endmodule

[sv/mjdg_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MJD to Gregorian date job queue
// Small register queue that lets the front end and the calendar pipeline
// stall independently.
// ----------------------------------------------------------------------------
module mjdg_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  input  mjdg_pkg::mjdg_job_t push_data_i,
  output logic                push_ready_o,
  output logic                pop_valid_o,
  output mjdg_pkg::mjdg_job_t pop_data_o,
  input  logic                pop_ready_i
);
  import mjdg_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mjdg_job_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[sv/mjdg_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MJD to Gregorian date calendar pipeline
// Converts a chronological Julian day number into year, month and day with
// constant divisions done as reciprocal multiplies and one correction step.
// ----------------------------------------------------------------------------
module mjdg_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  mjdg_pkg::mjdg_job_t job_i,
  output logic                job_ready_o,
  mjdg_out_if.source          out_o
);
  import mjdg_pkg::*;

  localparam int NSTG = 14;

  logic adv;

  logic [NSTG-1:0]   vld_q;
  logic [FRAC_W-1:0] frc_q [NSTG];
  logic              sts_q [NSTG];

  // Century term.
  logic [31:0] x1_q, x1b_q, x1c_q;
  logic [JD_W-1:0] jd0_q, jd1_q, jd2_q, jd3_q, jd4_q;
  logic [46:0] t_prod;
  logic [14:0] te1_q, te2_q, t3_q;
  logic [32:0] tp2_q, t_rem;
  logic [17:0] six_t;
  logic [15:0] h4_q;
  // Year and day of cycle.
  logic [31:0] n_sum, n4_q, n4b_q, n4c_q;
  logic [53:0] y_prod;
  logic [21:0] ye6_q, ye7_q, yq8_q;
  logic [32:0] yp7_q, y_rem;
  logic [10:0] ry8_q, k9_q;
  logic signed [YEAR_W-1:0] yr9_q, yr10_q, yr11_q, yr12_q, yr13_q;
  // Month and day.
  logic [8:0]  d4;
  logic [11:0] nd10_q, nd11_q;
  logic [19:0] m_prod;
  logic [3:0]  mqe11_q, mq12_q, mon13_q;
  logic [12:0] m_rem;
  logic [8:0]  dr12_q, dr13_q;
  logic [4:0]  mm;
  logic [16:0] d_prod;
  logic [4:0]  de13_q;
  logic [8:0]  d_rem;

  logic signed [YEAR_W-1:0] year_q;
  logic [MONTH_W-1:0]       month_q;
  logic [DAY_W-1:0]         day_q;
  logic [FRAC_W-1:0]        frac_q;
  logic                     status_q, out_vld_q;

  assign adv         = !out_vld_q || out_o.ready;
  assign job_ready_o = adv;

  assign t_prod = 47'(x1_q) * 47'(RECIP_CYCLE);
  assign t_rem  = 33'(x1c_q) - tp2_q;
  assign six_t  = 18'({t3_q, 2'b00}) + 18'({t3_q, 1'b0});
  assign n_sum  = 32'(jd4_q) + 32'(h4_q) - CAL_SHIFT;
  assign y_prod = 54'(n4_q) * 54'(RECIP_LEAP);
  assign y_rem  = 33'(n4c_q) - yp7_q;
  assign d4     = k9_q[10:2];
  assign m_prod = 20'(nd10_q) * 20'(RECIP_SPAN);
  assign m_rem  = 13'(nd11_q) - 13'(mqe11_q) * 13'(MONTH_SPAN);
  assign mm     = 5'(mq12_q) + 5'd2;
  assign d_prod = 17'(dr12_q) * 17'(RECIP_TEN);
  assign d_rem  = dr13_q - 9'(de13_q) * 9'd10;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[NSTG-2:0], job_valid_i};
      out_vld_q <= vld_q[NSTG-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      frc_q[0] <= job_i.frac;
      sts_q[0] <= job_i.status;
      for (int i = 1; i < NSTG; i++) begin
        frc_q[i] <= frc_q[i-1];
        sts_q[i] <= sts_q[i-1];
      end

      // (4*jd - bias) / 146097
      jd0_q <= job_i.jd;
      x1_q  <= {job_i.jd, 2'b00} - CAL_BIAS;
      jd1_q <= jd0_q;
      x1b_q <= x1_q;
      te1_q <= t_prod[46:32];
      jd2_q <= jd1_q;
      x1c_q <= x1b_q;
      te2_q <= te1_q;
      tp2_q <= 33'(te1_q) * 33'(CAL_CYCLE);
      jd3_q <= jd2_q;
      t3_q  <= (t_rem[18:0] >= 19'(CAL_CYCLE)) ? te2_q + 15'd1 : te2_q;
      // ((6t/4) + 1) / 2
      jd4_q <= jd3_q;
      h4_q  <= 16'((17'(six_t[17:2]) + 17'd1) >> 1);
      n4_q  <= {n_sum[29:0], 2'b00};

      // n4 / 1461 and n4 % 1461
      n4b_q <= n4_q;
      ye6_q <= y_prod[53:32];
      n4c_q <= n4b_q;
      ye7_q <= ye6_q;
      yp7_q <= 33'(ye6_q) * 33'(LEAP_CYCLE);
      if (y_rem[11:0] >= 12'(LEAP_CYCLE)) begin
        yq8_q <= ye7_q + 22'd1;
        ry8_q <= 11'(y_rem[11:0] - 12'(LEAP_CYCLE));
      end else begin
        yq8_q <= ye7_q;
        ry8_q <= y_rem[10:0];
      end
      yr9_q <= $signed(23'(yq8_q) - YEAR_BIAS);
      k9_q  <= (ry8_q >= MONTH_BIAS) ? ry8_q - MONTH_BIAS : ry8_q + MONTH_WRAP;

      // nd10 = 10 * (k / 4) + 5, then split by 306 and by 10.
      yr10_q  <= yr9_q;
      nd10_q  <= {d4, 3'b000} + 12'({d4, 1'b0}) + 12'd5;
      yr11_q  <= yr10_q;
      nd11_q  <= nd10_q;
      mqe11_q <= m_prod[19:16];
      yr12_q  <= yr11_q;
      if (m_rem[9:0] >= MONTH_SPAN) begin
        mq12_q <= mqe11_q + 4'd1;
        dr12_q <= 9'(m_rem[9:0] - MONTH_SPAN);
      end else begin
        mq12_q <= mqe11_q;
        dr12_q <= m_rem[8:0];
      end
      yr13_q  <= yr12_q;
      mon13_q <= 4'(((mm >= 5'd12) ? mm - 5'd12 : mm) + 5'd1);
      dr13_q  <= dr12_q;
      de13_q  <= d_prod[16:12];

      // Output register; out-of-range dates show zeros.
      status_q <= sts_q[NSTG-1];
      if (sts_q[NSTG-1]) begin
        year_q  <= '0;
        month_q <= '0;
        day_q   <= '0;
        frac_q  <= '0;
      end else begin
        year_q  <= yr13_q;
        month_q <= mon13_q;
        day_q   <= ((d_rem >= 9'd10) ? de13_q + 5'd1 : de13_q) + 5'd1;
        frac_q  <= frc_q[NSTG-1];
      end
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.year         = year_q;
  assign out_o.month        = month_q;
  assign out_o.day_of_month = day_q;
  assign out_o.day_fraction = frac_q;
  assign out_o.status       = status_q;

endmodule

[sv/mjd_to_gregorian_date_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MJD to Gregorian date converter
// Rounds a fixed-point Modified Julian Date to a configured number of decimal
// places of a day and converts it to a Gregorian year, month and day.
// ----------------------------------------------------------------------------
//
//   Channel          Direction  Beat contents
//   in_i             sink       mjd_fixed (signed, FRAC_BITS fraction bits)
//   out_o            source     year, month, day_of_month, day_fraction, status
//   fraction_digits  write      3-bit digit count, taken when the enable is high
//
// The block accepts one beat per cycle and delivers one result beat per cycle
// while out_o does not stall. The fixed rate is set by the front stages and
// the calendar pipeline, each one register per step, with no iterating unit.
// An accepted beat passes two front stages, the queue's storage register and
// fourteen calendar stages ahead of the output register.
// Reset clears all valid flags and the queue and sets the digit count to one.
// A stall on out_o freezes the calendar pipeline; the queue then absorbs the
// front end's beats until it fills, after which in_i.ready drops.
// ----------------------------------------------------------------------------
module mjd_to_gregorian_date_top #(
  parameter int FRAC_BITS   = 24,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fraction_digits_we_i,
  input  logic [mjdg_pkg::DIGITS_W-1:0] fraction_digits_i,
  mjdg_in_if.sink                       in_i,
  mjdg_out_if.source                    out_o
);
  import mjdg_pkg::*;

  // Digit count register. Values above four are kept as written and act as
  // four through the scale lookup.
  logic [DIGITS_W-1:0] fraction_digits_q;
  logic [FRAC_W-1:0]   fd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fraction_digits_q <= DIGITS_RESET;
    end else if (fraction_digits_we_i) begin
      fraction_digits_q <= fraction_digits_i;
    end
  end

  assign fd = fd_for_digits(fraction_digits_q);

  // The front end classifies each date (in range or not), rounds it and
  // splits it into a Julian day number and a fraction count.
  mjdg_job_t front_job, queue_job;
  logic      front_valid, front_ready;
  logic      queue_valid, queue_ready;

  mjdg_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fd_i        (fd),
    .in_i        (in_i),
    .job_valid_o (front_valid),
    .job_o       (front_job),
    .job_ready_i (front_ready)
  );

  // The queue decouples the front end from the calendar pipeline so that a
  // short stall at the output does not reach the input at once.
  mjdg_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_data_i  (front_job),
    .push_ready_o (front_ready),
    .pop_valid_o  (queue_valid),
    .pop_data_o   (queue_job),
    .pop_ready_i  (queue_ready)
  );

  // The calendar pipeline turns the day number into year, month and day and
  // holds each result in its output register until the sink takes it.
  mjdg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (queue_valid),
    .job_i       (queue_job),
    .job_ready_o (queue_ready),
    .out_o       (out_o)
  );

endmodule

[tb/mjdg_date_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MJD to Gregorian date result checker
// Watches the date and result channels and the digit register port. Predicts
// the calendar result of every accepted date beat and compares each result
// beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module mjdg_date_checker #(
  parameter int FRAC_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          digits_we_i,
  input  logic [mjdg_pkg::DIGITS_W-1:0] digits_i,
  mjdg_in_if                            in_i,
  mjdg_out_if                           out_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            checked_o
);
  import mjdg_pkg::*;

  localparam logic [DIGITS_W-1:0] DIGITS_AT_RESET = 3'd1;
  localparam int                  MAX_DIGITS      = 4;

  localparam longint unsigned LOW_EDGE  = 64'd2395520 << FRAC_BITS;
  localparam longint unsigned HIGH_EDGE = 64'd1000000000 << FRAC_BITS;
  localparam longint unsigned HALF_UNIT = 64'd1 << (FRAC_BITS - 1);
  localparam longint unsigned FRAC_MASK = (64'd1 << FRAC_BITS) - 64'd1;

  localparam longint MJD_TO_JD   = 2400001;
  localparam longint GREG_BIAS   = 17918;
  localparam longint GREG_CYCLE  = 146097;
  localparam longint GREG_SHIFT  = 37;
  localparam longint QUAD_YEARS  = 1461;
  localparam longint MARCH_BIAS  = 237;
  localparam longint MONTH_DAYS5 = 306;
  localparam longint EPOCH_YEAR  = 4712;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day_of_month;
    logic [FRAC_W-1:0]  day_fraction;
    logic               status;
  } date_beat_t;

  logic [DIGITS_W-1:0] digits_q;
  date_beat_t          expected_dates[$];

  // Calendar date of one fixed-point MJD at a given digit count.
  function automatic date_beat_t date_of(input logic [MJD_W-1:0] raw,
                                         input logic [DIGITS_W-1:0] digits);
    logic [MJD_W-1:0] neg_raw;
    logic             neg;
    longint unsigned  mag, whole, part, rmag;
    longint           fd, df, q, r, jd, n4, nd10, yr, mon, dy;
    int               eff;
    date_beat_t       res;
    res     = '0;
    neg     = raw[MJD_W-1];
    neg_raw = ~raw + 1'b1;
    mag     = neg ? longint'(neg_raw) : longint'(raw);
    if ((neg && mag >= LOW_EDGE) || (!neg && mag >= HIGH_EDGE)) begin
      res.status = 1'b1;
      return res;
    end
    eff = (digits > MAX_DIGITS) ? MAX_DIGITS : int'(digits);
    fd  = 1;
    repeat (eff) fd *= 10;
    // Round the magnitude of date * 10^digits, half up, so the signed value
    // rounds half away from zero.
    whole = mag >> FRAC_BITS;
    part  = mag & FRAC_MASK;
    rmag  = whole * fd + ((part * fd + HALF_UNIT) >> FRAC_BITS);
    df    = neg ? -longint'(rmag) : longint'(rmag);
    // Floor split: the fraction count never goes negative.
    q = df / fd;
    r = df % fd;
    if (r < 0) begin
      r += fd;
      q -= 1;
    end
    jd   = q + MJD_TO_JD;
    n4   = 4 * (jd + ((2 * ((4 * jd - GREG_BIAS) / GREG_CYCLE) * 3) / 4 + 1) / 2
                - GREG_SHIFT);
    nd10 = 10 * (((n4 - MARCH_BIAS) % QUAD_YEARS) / 4) + 5;
    yr   = n4 / QUAD_YEARS - EPOCH_YEAR;
    mon  = ((nd10 / MONTH_DAYS5 + 2) % 12) + 1;
    dy   = (nd10 % MONTH_DAYS5) / 10 + 1;
    res.year         = yr[YEAR_W-1:0];
    res.month        = mon[MONTH_W-1:0];
    res.day_of_month = dy[DAY_W-1:0];
    res.day_fraction = r[FRAC_W-1:0];
    return res;
  endfunction

  task automatic compare_field(input string field, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    date_beat_t want;
    if (!rst_ni) begin
      digits_q <= DIGITS_AT_RESET;
      expected_dates.delete();
      pending_o <= 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        if (expected_dates.size() == 0) begin
          $error("result beat with no date outstanding");
          fail_count_o++;
        end else begin
          want = expected_dates.pop_front();
          compare_field("year", longint'($signed(want.year)), longint'($signed(out_i.year)));
          compare_field("month", longint'(want.month), longint'(out_i.month));
          compare_field("day_of_month", longint'(want.day_of_month),
                        longint'(out_i.day_of_month));
          compare_field("day_fraction", longint'(want.day_fraction),
                        longint'(out_i.day_fraction));
          compare_field("status", longint'(want.status), longint'(out_i.status));
          checked_o++;
        end
      end
      if (in_i.valid && in_i.ready) begin
        expected_dates.push_back(date_of(in_i.mjd_fixed, digits_q));
      end
      if (digits_we_i) begin
        digits_q <= digits_i;
      end
      pending_o <= expected_dates.size();
    end
  end

endmodule

[tb/mjd_to_gregorian_date_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MJD to Gregorian date converter testbench
// Drives fixed-point dates through the converter under random flow control on
// both channels and across every digit count, and leaves prediction and
// comparison to a checker placed beside the block.
// ----------------------------------------------------------------------------
module mjd_to_gregorian_date_top_tb;
  import mjdg_pkg::*;

  localparam int     FRAC_BITS       = 24;
  localparam longint DAY             = 64'sd1 << FRAC_BITS;
  localparam int     ITEMS_PER_PHASE = 130;
  // Phase indexes where the flow-control pressure tests take place.
  localparam int     PRESSURE_PHASE  = 2;
  localparam int     PAUSE_PHASE     = 3;
  // Cycles the result side holds off during the pressure test.
  localparam int     LONG_HOLD       = 150;
  // A margin beyond the pipeline depth of the block.
  localparam int     SETTLE_CYCLES   = 24;

  logic                clk   = 1'b0;
  logic                rst_n = 1'b0;
  logic                digits_we;
  logic [DIGITS_W-1:0] digits_val;

  mjdg_in_if  in_b ();
  mjdg_out_if out_b ();

  int fail_count;
  int pending;
  int checked;
  int sent_count;
  int digit_writes;
  int hold_requests;
  bit src_gaps_on;

  mjd_to_gregorian_date_top #(
    .FRAC_BITS (FRAC_BITS)
  ) DUT (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .fraction_digits_we_i (digits_we),
    .fraction_digits_i    (digits_val),
    .in_i                 (in_b),
    .out_o                (out_b)
  );

  mjdg_date_checker #(
    .FRAC_BITS (FRAC_BITS)
  ) date_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .digits_we_i  (digits_we),
    .digits_i     (digits_val),
    .in_i         (in_b),
    .out_i        (out_b),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always #6 clk = ~clk;

  // Idle length for either side: mostly none, often a short gap, now and then
  // a long one.
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // A random date, weighted toward the places where the arithmetic turns:
  // the range edges, the rounding half points and the ends of a day.
  function automatic logic [MJD_W-1:0] rand_date();
    int     pick;
    longint day, frac, div, k, v;
    pick = $urandom_range(99);
    frac = longint'($urandom_range((1 << FRAC_BITS) - 1, 0));
    day  = longint'($urandom_range(99999, 0));
    if ($urandom_range(1)) begin
      day = -day;
    end
    if (pick < 30) begin
      v = longint'($urandom_range(99999, 0)) * DAY + frac;
    end else if (pick < 45) begin
      v = -longint'($urandom_range(2395519, 1)) * DAY + frac;
    end else if (pick < 60) begin
      v = (longint'($urandom_range(1002395518, 0)) - 2395519) * DAY + frac;
    end else if (pick < 68) begin
      v = -2395520 * DAY + longint'($urandom_range(8)) - 4;
    end else if (pick < 76) begin
      v = 1000000000 * DAY + longint'($urandom_range(8)) - 4;
    end else if (pick < 88) begin
      // Near a multiple of half a rounding step for some digit count.
      div = 2;
      repeat ($urandom_range(4)) div *= 10;
      k = longint'($urandom_range(int'(div) - 1, 0));
      v = day * DAY + (((k * DAY) / div + longint'($urandom_range(2)) - 1) & (DAY - 1));
    end else if (pick < 94) begin
      case ($urandom_range(2))
        0:       v = day * DAY;
        1:       v = day * DAY + 1;
        default: v = day * DAY + DAY - 1;
      endcase
    end else begin
      v = {$urandom, $urandom};
    end
    return v[MJD_W-1:0];
  endfunction

  // Offers one date beat and returns once it has been accepted. The valid
  // line is touched once per edge: it either drops for a gap or carries the
  // new beat straight after the previous one.
  task automatic send_date(input logic [MJD_W-1:0] v);
    int gap;
    gap = src_gaps_on ? idle_len() : 0;
    if (gap > 0) begin
      in_b.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_b.valid     <= 1'b1;
    in_b.mjd_fixed <= v;
    @(posedge clk);
    while (!in_b.ready) @(posedge clk);
    sent_count++;
  endtask

  // Stops offering beats, waits for every predicted result to come back and
  // then lets the pipeline run empty for a little longer.
  task automatic settle();
    in_b.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The digit register is only written while the block holds no work.
  task automatic set_digits(input logic [DIGITS_W-1:0] d);
    settle();
    digits_we  <= 1'b1;
    digits_val <= d;
    @(posedge clk);
    digits_we  <= 1'b0;
    digit_writes++;
  endtask

  // Result side: random stalls, calm stretches with ready held high, and on
  // request one long hold-off counted here so that the block fills up and
  // pushes back on the date channel.
  initial begin : result_sink
    int stall_left;
    int calm_left;
    int holds_done;
    stall_left  = 0;
    calm_left   = 0;
    holds_done  = 0;
    out_b.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (holds_done != hold_requests) begin
        holds_done++;
        out_b.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (stall_left > 0) begin
        out_b.ready <= 1'b0;
        stall_left--;
        @(posedge clk);
      end else begin
        out_b.ready <= 1'b1;
        if (calm_left > 0) begin
          calm_left--;
        end else if ($urandom_range(99) < 3) begin
          calm_left = 120;
        end else begin
          stall_left = idle_len();
        end
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [DIGITS_W-1:0] phase_digits [8];
    phase_digits   = '{3'd0, 3'd4, 3'd2, 3'd3, 3'd7, 3'd1, 3'd5, 3'd6};
    in_b.valid     <= 1'b0;
    in_b.mjd_fixed <= '0;
    digits_we      <= 1'b0;
    digits_val     <= '0;
    src_gaps_on    = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed dates at the digit count left by reset (one decimal place).
    send_date('0);
    send_date(MJD_W'(1));
    send_date('1);                                 // just below zero
    send_date({1'b0, {(MJD_W - 1){1'b1}}});        // largest input, out of range
    send_date({1'b1, {(MJD_W - 1){1'b0}}});        // smallest input, out of range
    send_date(MJD_W'(1000000000 * DAY - 1));       // last date before the upper edge
    send_date(MJD_W'(1000000000 * DAY));           // upper edge itself
    send_date(MJD_W'(-2395520 * DAY));             // lower edge itself
    send_date(MJD_W'(-2395520 * DAY + 1));         // first date above the lower edge
    send_date(MJD_W'(51544 * DAY));                // start of the year 2000
    send_date(MJD_W'(51603 * DAY));                // leap day of 2000
    send_date(MJD_W'(15078 * DAY));                // around the end of February 1900
    send_date(MJD_W'(51544 * DAY + DAY - 1));      // rounds up into the next day
    send_date(MJD_W'(-(DAY * 3) / 10));            // negative fraction folds upward
    send_date(MJD_W'(60000 * DAY + DAY / 2));

    // Whole days only: exact half points round away from zero.
    set_digits(3'd0);
    send_date(MJD_W'(DAY / 2));
    send_date(MJD_W'(-DAY / 2));
    send_date(MJD_W'(3 * DAY / 2));
    send_date(MJD_W'(-3 * DAY / 2));
    send_date(MJD_W'(DAY / 2 - 1));

    // Finest step, at both ends of a day.
    set_digits(3'd4);
    send_date(MJD_W'(DAY - 1));
    send_date('1);
    send_date(MJD_W'(12345 * DAY + (DAY * 9999) / 10000));

    // Random phases, one per digit count, counts above four included.
    foreach (phase_digits[p]) begin
      set_digits(phase_digits[p]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == PRESSURE_PHASE && n == 10) begin
          // Back-to-back beats while the result side holds off.
          src_gaps_on   = 1'b0;
          hold_requests <= hold_requests + 1;
        end
        if (p == PRESSURE_PHASE && n == 70) begin
          src_gaps_on = 1'b1;
        end
        if (p == PAUSE_PHASE && n == ITEMS_PER_PHASE / 2) begin
          settle();
        end
        send_date(rand_date());
      end
    end

    settle();
    $display("Covered %0d dates over %0d digit register writes plus the reset count;",
             sent_count, digit_writes);
    $display("%0d results compared, including range edges and rounding half points.",
             checked);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin : watchdog
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
